// File: rtl/rca_pkg.sv
`timescale 1ns / 1ps
package rca_pkg;

	localparam int MAX_CHUNKS = 16;
	localparam int SLOT_W     = $clog2(MAX_CHUNKS);
	localparam int OFF_W      = 20;
	localparam int LEN_W      = 21;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	localparam logic [LEN_W-1:0] MAX_BUFFER_BYTES = LEN_W'(1048576);

	// register index within the APB map (address bit 2)
	localparam logic REG_BUFFER_SIZE = 1'b0;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [2:0] {
		STAT_OK         = 3'd0,
		STAT_NO_SPACE   = 3'd1,
		STAT_BAD_LEN    = 3'd2,
		STAT_FULL       = 3'd3,
		STAT_BAD_HANDLE = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WALK,
		ST_LOAD,
		ST_FIN
	} state_t;

	// configuration write event toward the controller
	typedef struct packed {
		logic             wr;
		logic [LEN_W-1:0] size;
	} cfg_t;

endpackage

// File: rtl/ring_chunk_allocator.sv
`timescale 1ns / 1ps
// Ring chunk allocator.
// Request channel (req_valid/req_stall): cmd selects allocate or free; length
// is the allocate size, handle the slot to free. A request is taken at an edge
// with req_valid high and req_stall low; req_stall is high while a request is
// in work, one at a time.
// Response channel (rsp_valid/rsp_stall): one response per request with status,
// offset, granted_handle and free_space (unallocated bytes after the request).
// The response sits in an output register; while rsp_stall is high it holds,
// the block finishes the current request and waits before loading the next.
// Steps: the request is latched at the request edge, EXEC decides it, FIN loads the
// output register. A free of the oldest chunk first scans the slot valid bits one
// per cycle (WALK) for the next outstanding chunk and then reads its offset from
// the slot store (LOAD). A new request is taken only after FIN.
// APB: buffer_size at address 0; a write clamps it to 1..1048576 and empties
// the ring. Write only while no request is in flight.
// Reset: buffer_size 1048576, ring empty, slot counters at zero, no response.
module ring_chunk_allocator
	import rca_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic              cmd,
	input  logic [LEN_W-1:0]  length,
	input  logic [SLOT_W-1:0] handle,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [2:0]        status,
	output logic [OFF_W-1:0]  offset,
	output logic [SLOT_W-1:0] granted_handle,
	output logic [LEN_W-1:0]  free_space,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	cfg_t cfg;

	rca_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rca_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.cmd            (cmd),
		.length         (length),
		.handle         (handle),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.status         (status),
		.offset         (offset),
		.granted_handle (granted_handle),
		.free_space     (free_space)
	);

endmodule

// File: rtl/rca_cfg.sv
`timescale 1ns / 1ps
module rca_cfg
	import rca_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [LEN_W-1:0] size_q;
	logic [LEN_W-1:0] wval;
	logic             hit;

	assign pready = 1'b1;
	assign hit    = psel && penable && pwrite && (paddr[2] == REG_BUFFER_SIZE);

	// clamp written size to 1..MAX_BUFFER_BYTES
	always_comb begin
		wval = pwdata[LEN_W-1:0];
		if (wval == '0) begin
			wval = LEN_W'(1);
		end else if (wval > MAX_BUFFER_BYTES) begin
			wval = MAX_BUFFER_BYTES;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= MAX_BUFFER_BYTES;
		end else if (hit) begin
			size_q <= wval;
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_BUFFER_SIZE) begin
			prdata = APB_DW'(size_q);
		end
	end

	assign cfg.wr   = hit;
	assign cfg.size = size_q;

endmodule

// File: rtl/rca_ctrl.sv
`timescale 1ns / 1ps
module rca_ctrl
	import rca_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic              cmd,
	input  logic [LEN_W-1:0]  length,
	input  logic [SLOT_W-1:0] handle,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [2:0]        status,
	output logic [OFF_W-1:0]  offset,
	output logic [SLOT_W-1:0] granted_handle,
	output logic [LEN_W-1:0]  free_space
);

	state_t state_q, state_d;

	// slot offset store, one read and one write port
	logic [OFF_W-1:0]  mem [MAX_CHUNKS];
	logic [OFF_W-1:0]  rdata_s1;
	logic [SLOT_W-1:0] raddr;
	logic              mem_we;

	logic [MAX_CHUNKS-1:0] valid_q;
	logic [SLOT_W-1:0]     oldest_q, next_q, k_q;
	logic [LEN_W-1:0]      ff_q;
	logic [OFF_W-1:0]      head_q;

	// latched request
	logic              cmd_q;
	logic [LEN_W-1:0]  len_q;
	logic [SLOT_W-1:0] hnd_q;

	// pending result
	status_t           st_q;
	logic [OFF_W-1:0]  off_q;
	logic [SLOT_W-1:0] gh_q;

	logic              rsp_valid_q;
	logic [2:0]        rsp_status_q;
	logic [OFF_W-1:0]  rsp_off_q;
	logic [SLOT_W-1:0] rsp_gh_q;
	logic [LEN_W-1:0]  rsp_space_q;

	logic              accept;
	logic              empty;
	logic              len_bad, full, fits;
	logic [OFF_W-1:0]  pos;
	logic [LEN_W-1:0]  head_ext;
	logic [SLOT_W-1:0] walk_idx;
	logic              walk_hit, walk_last;
	logic              fin_load;
	logic [LEN_W-1:0]  space;
	logic              alloc_ok, free_ok;

	assign accept    = req_valid && (state_q == ST_IDLE);
	assign req_stall = (state_q != ST_IDLE);
	assign empty     = !valid_q[oldest_q];
	assign head_ext  = LEN_W'(rdata_s1);
	assign walk_idx  = oldest_q + k_q;
	assign walk_hit  = valid_q[walk_idx];
	assign walk_last = (k_q == SLOT_W'(MAX_CHUNKS - 1));
	assign fin_load  = !rsp_valid_q || !rsp_stall;

	// the store is written only in EXEC and read for the next item after FIN,
	// so a read never overlaps a write of the same entry
	assign raddr = (state_q == ST_WALK) ? walk_idx : oldest_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[next_q] <= pos;
		end
		rdata_s1 <= mem[raddr];
	end

	// allocate placement
	always_comb begin
		len_bad = (len_q == '0) || (len_q > cfg.size);
		full    = valid_q[next_q];
		fits    = 1'b0;
		pos     = '0;
		if (empty) begin
			fits = 1'b1;
		end else if (ff_q <= head_ext) begin
			if (head_ext - ff_q >= len_q) begin
				fits = 1'b1;
				pos  = ff_q[OFF_W-1:0];
			end
		end else if (cfg.size - ff_q >= len_q) begin
			fits = 1'b1;
			pos  = ff_q[OFF_W-1:0];
		end else if (head_ext >= len_q) begin
			fits = 1'b1;
		end
	end

	assign alloc_ok = (state_q == ST_EXEC) && (cmd_q == CMD_ALLOC) && !len_bad && !full && fits;
	assign free_ok  = (state_q == ST_EXEC) && (cmd_q == CMD_FREE) && valid_q[hnd_q];
	assign mem_we   = alloc_ok;

	// unallocated bytes from the committed state
	always_comb begin
		if (empty) begin
			space = cfg.size;
		end else if (LEN_W'(head_q) >= ff_q) begin
			space = LEN_W'(head_q) - ff_q;
		end else begin
			space = cfg.size - ff_q + LEN_W'(head_q);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (free_ok && (hnd_q == oldest_q)) begin
					state_d = ST_WALK;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_WALK: begin
				if (walk_hit) begin
					state_d = ST_LOAD;
				end else if (walk_last) begin
					state_d = ST_FIN;
				end
			end
			ST_LOAD: state_d = ST_FIN;
			ST_FIN: begin
				if (fin_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ring control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			oldest_q <= '0;
			next_q   <= '0;
			ff_q     <= '0;
		end else if (cfg.wr) begin
			valid_q  <= '0;
			ff_q     <= '0;
			oldest_q <= next_q;
		end else begin
			if (alloc_ok) begin
				valid_q[next_q] <= 1'b1;
				ff_q            <= LEN_W'({1'b0, pos} + len_q);
				next_q          <= next_q + 1'b1;
				if (empty) begin
					oldest_q <= next_q;
				end
			end
			if (free_ok) begin
				valid_q[hnd_q] <= 1'b0;
			end
			if (state_q == ST_WALK) begin
				if (walk_hit) begin
					oldest_q <= walk_idx;
				end else if (walk_last) begin
					oldest_q <= next_q;
				end
			end
		end
	end

	// request latch, walk counter, cached head offset, pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			len_q <= length;
			hnd_q <= handle;
		end
		if (state_q == ST_EXEC) begin
			k_q    <= SLOT_W'(1);
			head_q <= (alloc_ok && empty) ? pos : rdata_s1;
			off_q  <= '0;
			gh_q   <= '0;
			if (cmd_q == CMD_ALLOC) begin
				if (len_bad) begin
					st_q <= STAT_BAD_LEN;
				end else if (full) begin
					st_q <= STAT_FULL;
				end else if (!fits) begin
					st_q <= STAT_NO_SPACE;
				end else begin
					st_q  <= STAT_OK;
					off_q <= pos;
					gh_q  <= next_q;
				end
			end else begin
				st_q <= valid_q[hnd_q] ? STAT_OK : STAT_BAD_HANDLE;
			end
		end
		if (state_q == ST_WALK) begin
			k_q <= k_q + 1'b1;
		end
		if (state_q == ST_LOAD) begin
			head_q <= rdata_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && fin_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && fin_load) begin
			rsp_status_q <= st_q;
			rsp_off_q    <= off_q;
			rsp_gh_q     <= gh_q;
			rsp_space_q  <= space;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign status         = rsp_status_q;
	assign offset         = rsp_off_q;
	assign granted_handle = rsp_gh_q;
	assign free_space     = rsp_space_q;

endmodule
